// ===== design/ffsa_pkg.sv =====
// Shared types, codes and constants of the first-fit segment allocator.
package ffsa_pkg;

    localparam int LEN_W = 17;
    localparam int ADDR_W = 32;
    localparam int DEF_MAX_SEGMENTS = 16;
    localparam int DEF_OFFSET_BITS = 16;
    localparam logic [LEN_W-1:0] POOL_SIZE_RESET = 17'd65536;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    localparam logic REG_POOL_BASE = 1'b0;
    localparam logic REG_POOL_SIZE = 1'b1;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_NOSPACE = 2'd1;
    localparam logic [1:0] STATUS_NOTALLOC = 2'd2;
    localparam logic [1:0] STATUS_FULL = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_LOAD,
        ST_SHIFT,
        ST_PUT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic fit;
        logic hit;
    } unit_flags_t;

    typedef struct packed {
        logic             clear;
        logic [LEN_W-1:0] len;
    } pool_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  free;
    } result_t;

    // The stored pool length never exceeds the span of the offset field.
    function automatic logic [LEN_W-1:0] cap_pool_len(input logic [LEN_W-1:0] v, input int ob);
        logic [32:0] cap;
        logic [32:0] ext;
        cap = 33'(1) << ob;
        ext = 33'(v);
        if (ext > cap)
        begin
            return cap[LEN_W-1:0];
        end
        return v;
    endfunction

endpackage

// ===== design/ffsa_table.sv =====
// Segment table memory with one write port and one registered read port.
module ffsa_table #(
    parameter int DEPTH = ffsa_pkg::DEF_MAX_SEGMENTS,
    parameter int WIDTH = ffsa_pkg::DEF_OFFSET_BITS + ffsa_pkg::LEN_W
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ffsa_unit.sv =====
// Shared compare and address unit used by every step of the table scan.
module ffsa_unit #(
    parameter int OFFSET_BITS = ffsa_pkg::DEF_OFFSET_BITS
) (
    input  logic [OFFSET_BITS:0]          hi,
    input  logic [OFFSET_BITS:0]          lo,
    input  logic [ffsa_pkg::LEN_W-1:0]    need,
    input  logic [OFFSET_BITS-1:0]        seg_off,
    input  logic [ffsa_pkg::LEN_W-1:0]    seg_len,
    input  logic [OFFSET_BITS-1:0]        addr_off,
    input  logic [ffsa_pkg::ADDR_W-1:0]   base,
    input  logic [ffsa_pkg::ADDR_W-1:0]   match_addr,
    output ffsa_pkg::unit_flags_t         flags,
    output logic [OFFSET_BITS:0]          seg_end,
    output logic [ffsa_pkg::ADDR_W-1:0]   addr_sum
);

    localparam int EW = OFFSET_BITS + 1;
    localparam int CW = ((EW > ffsa_pkg::LEN_W) ? EW : ffsa_pkg::LEN_W) + 1;

    logic [CW-1:0] hi_x;
    logic [CW-1:0] lo_x;
    logic [CW-1:0] need_x;
    logic [CW-1:0] gap;

    always_comb
    begin
        hi_x = CW'(hi);
        lo_x = CW'(lo);
        need_x = CW'(need);
        gap = hi_x - lo_x;
        addr_sum = base + ffsa_pkg::ADDR_W'(addr_off);
        seg_end = EW'(seg_off) + EW'(seg_len);
        flags.fit = (hi_x >= lo_x) && (gap >= need_x);
        flags.hit = (base + ffsa_pkg::ADDR_W'(seg_off)) == match_addr;
    end

endmodule

// ===== design/ffsa_ctrl.sv =====
// Request sequencer: table scan, entry shifting and free byte accounting.
module ffsa_ctrl #(
    parameter int MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS,
    parameter int OFFSET_BITS = ffsa_pkg::DEF_OFFSET_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [ffsa_pkg::LEN_W-1:0]    req_size,
    input  logic [ffsa_pkg::ADDR_W-1:0]   req_address,
    input  logic [ffsa_pkg::ADDR_W-1:0]   pool_base,
    input  logic [ffsa_pkg::LEN_W-1:0]    pool_len,
    input  ffsa_pkg::pool_cmd_t           pool_cmd,
    input  logic                          out_free,
    output ffsa_pkg::result_t             res
);

    localparam int EW = OFFSET_BITS + 1;
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
    localparam int DW = OFFSET_BITS + ffsa_pkg::LEN_W;
    localparam int LW = ffsa_pkg::LEN_W;
    localparam logic [LW-1:0] LEN_RESET =
        ffsa_pkg::cap_pool_len(ffsa_pkg::POOL_SIZE_RESET, OFFSET_BITS);

    ffsa_pkg::ctrl_state_t state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [LW-1:0]   free_reg, free_next;
    logic [CNTW-1:0] idx_reg, idx_next;
    logic [CNTW-1:0] pos_reg, pos_next;
    logic [CNTW-1:0] ptr_reg, ptr_next;
    logic [EW-1:0]   prev_end_reg, prev_end_next;
    logic            op_reg, op_next;
    logic [LW-1:0]   n_reg, n_next;
    logic [ffsa_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [1:0]      status_reg, status_next;
    logic [ffsa_pkg::ADDR_W-1:0] baddr_reg, baddr_next;

    logic            take;
    logic [CNTW-1:0] idx_inc;
    logic [CNTW-1:0] ptr_dec2;
    logic [CNTW-1:0] ptr_inc2;
    logic            last;
    logic            full;
    logic [LW:0]     free_sum;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [DW-1:0]   mem_wd;
    logic [AW-1:0]   mem_ra;
    logic [DW-1:0]   mem_rd;
    logic [OFFSET_BITS-1:0] rd_off;
    logic [LW-1:0]   rd_len;
    logic [EW-1:0]   u_hi;
    logic [OFFSET_BITS-1:0] u_addr_off;
    ffsa_pkg::unit_flags_t u_flags;
    logic [EW-1:0]   u_end;
    logic [ffsa_pkg::ADDR_W-1:0] u_sum;

    function automatic logic [AW-1:0] idx_dec_cnt(input logic [CNTW-1:0] c);
        logic [CNTW-1:0] d;
        d = c - CNTW'(1);
        return d[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] idx_inc_pos(input logic [CNTW-1:0] p);
        logic [CNTW-1:0] d;
        d = p + CNTW'(1);
        return d[AW-1:0];
    endfunction

    ffsa_table #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (DW)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_addr (mem_ra),
        .rd_data (mem_rd)
    );

    assign rd_off = mem_rd[DW-1:LW];
    assign rd_len = mem_rd[LW-1:0];
    assign u_hi = (state_reg == ffsa_pkg::ST_TAIL) ? EW'(pool_len) : EW'(rd_off);
    assign u_addr_off = (state_reg == ffsa_pkg::ST_PUT) ? prev_end_reg[OFFSET_BITS-1:0] : rd_off;

    ffsa_unit #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_unit (
        .hi         (u_hi),
        .lo         (prev_end_reg),
        .need       (n_reg),
        .seg_off    (rd_off),
        .seg_len    (rd_len),
        .addr_off   (u_addr_off),
        .base       (pool_base),
        .match_addr (addr_reg),
        .flags      (u_flags),
        .seg_end    (u_end),
        .addr_sum   (u_sum)
    );

    assign in_stall = (state_reg != ffsa_pkg::ST_IDLE);
    assign take = in_valid && !in_stall;
    assign idx_inc = idx_reg + CNTW'(1);
    assign ptr_dec2 = ptr_reg - CNTW'(2);
    assign ptr_inc2 = ptr_reg + CNTW'(2);
    assign last = (idx_inc == count_reg);
    assign full = (count_reg == CNTW'(MAX_SEGMENTS));
    assign free_sum = {1'b0, free_reg} + {1'b0, rd_len};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffsa_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if (op == ffsa_pkg::OP_ALLOC)
                    begin
                        if ((req_size == '0) || full)
                        begin
                            state_next = ffsa_pkg::ST_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = ffsa_pkg::ST_TAIL;
                        end
                        else
                        begin
                            state_next = ffsa_pkg::ST_SCAN;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ffsa_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = ffsa_pkg::ST_SCAN;
                    end
                end
            end
            ffsa_pkg::ST_SCAN:
            begin
                if (op_reg == ffsa_pkg::OP_ALLOC)
                begin
                    if (u_flags.fit)
                    begin
                        state_next = ffsa_pkg::ST_LOAD;
                    end
                    else if (last)
                    begin
                        state_next = ffsa_pkg::ST_TAIL;
                    end
                end
                else if (u_flags.hit)
                begin
                    state_next = last ? ffsa_pkg::ST_DONE : ffsa_pkg::ST_LOAD;
                end
                else if (last)
                begin
                    state_next = ffsa_pkg::ST_DONE;
                end
            end
            ffsa_pkg::ST_TAIL:
            begin
                state_next = u_flags.fit ? ffsa_pkg::ST_PUT : ffsa_pkg::ST_DONE;
            end
            ffsa_pkg::ST_LOAD:
            begin
                state_next = ffsa_pkg::ST_SHIFT;
            end
            ffsa_pkg::ST_SHIFT:
            begin
                if (op_reg == ffsa_pkg::OP_ALLOC)
                begin
                    if (ptr_reg == (pos_reg + CNTW'(1)))
                    begin
                        state_next = ffsa_pkg::ST_PUT;
                    end
                end
                else if (ptr_inc2 == count_reg)
                begin
                    state_next = ffsa_pkg::ST_DONE;
                end
            end
            ffsa_pkg::ST_PUT:
            begin
                state_next = ffsa_pkg::ST_DONE;
            end
            ffsa_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ffsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        free_next = free_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        ptr_next = ptr_reg;
        prev_end_next = prev_end_reg;
        op_next = op_reg;
        n_next = n_reg;
        addr_next = addr_reg;
        status_next = status_reg;
        baddr_next = baddr_reg;
        mem_we = 1'b0;
        mem_wa = ptr_reg[AW-1:0];
        mem_wd = mem_rd;
        mem_ra = '0;
        res.valid = 1'b0;
        res.status = status_reg;
        res.addr = baddr_reg;
        res.free = free_reg;
        case (state_reg)
            ffsa_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    op_next = op;
                    n_next = req_size;
                    addr_next = req_address;
                    idx_next = '0;
                    prev_end_next = '0;
                    baddr_next = '0;
                    status_next = ffsa_pkg::STATUS_OK;
                    if (op == ffsa_pkg::OP_ALLOC)
                    begin
                        if (req_size == '0)
                        begin
                            status_next = ffsa_pkg::STATUS_NOSPACE;
                        end
                        else if (full)
                        begin
                            status_next = ffsa_pkg::STATUS_FULL;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ffsa_pkg::STATUS_NOTALLOC;
                    end
                end
            end
            ffsa_pkg::ST_SCAN:
            begin
                mem_ra = idx_inc[AW-1:0];
                idx_next = idx_inc;
                if (op_reg == ffsa_pkg::OP_ALLOC)
                begin
                    if (u_flags.fit)
                    begin
                        pos_next = idx_reg;
                    end
                    else
                    begin
                        prev_end_next = u_end;
                    end
                end
                else if (u_flags.hit)
                begin
                    pos_next = idx_reg;
                    free_next = (free_sum > {1'b0, pool_len}) ? pool_len : free_sum[LW-1:0];
                    if (last)
                    begin
                        count_next = count_reg - CNTW'(1);
                    end
                end
                else if (last)
                begin
                    status_next = ffsa_pkg::STATUS_NOTALLOC;
                end
            end
            ffsa_pkg::ST_TAIL:
            begin
                if (u_flags.fit)
                begin
                    pos_next = count_reg;
                end
                else
                begin
                    status_next = ffsa_pkg::STATUS_NOSPACE;
                end
            end
            ffsa_pkg::ST_LOAD:
            begin
                if (op_reg == ffsa_pkg::OP_ALLOC)
                begin
                    mem_ra = idx_dec_cnt(count_reg);
                    ptr_next = count_reg;
                end
                else
                begin
                    mem_ra = idx_inc_pos(pos_reg);
                    ptr_next = pos_reg;
                end
            end
            ffsa_pkg::ST_SHIFT:
            begin
                mem_we = 1'b1;
                if (op_reg == ffsa_pkg::OP_ALLOC)
                begin
                    mem_ra = ptr_dec2[AW-1:0];
                    ptr_next = ptr_reg - CNTW'(1);
                end
                else
                begin
                    mem_ra = ptr_inc2[AW-1:0];
                    ptr_next = ptr_reg + CNTW'(1);
                    if (ptr_inc2 == count_reg)
                    begin
                        count_next = count_reg - CNTW'(1);
                    end
                end
            end
            ffsa_pkg::ST_PUT:
            begin
                mem_we = 1'b1;
                mem_wa = pos_reg[AW-1:0];
                mem_wd = {prev_end_reg[OFFSET_BITS-1:0], n_reg};
                count_next = count_reg + CNTW'(1);
                free_next = (free_reg >= n_reg) ? (free_reg - n_reg) : '0;
                baddr_next = u_sum;
            end
            ffsa_pkg::ST_DONE:
            begin
                res.valid = out_free;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
        if (pool_cmd.clear)
        begin
            count_next = '0;
            free_next = pool_cmd.len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffsa_pkg::ST_IDLE;
            count_reg <= '0;
            free_reg <= LEN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        ptr_reg <= ptr_next;
        prev_end_reg <= prev_end_next;
        op_reg <= op_next;
        n_reg <= n_next;
        addr_reg <= addr_next;
        status_reg <= status_next;
        baddr_reg <= baddr_next;
    end

endmodule

// ===== design/first_fit_segment_allocator.sv =====
// Top level of the first-fit segment allocator: configuration, sequencer and result register.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   op, req_size, req_address
//   out      output     out_valid / out_stall status, block_address, bytes_free
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// After an item is accepted the input stalls while the table is scanned and entries are moved,
// and until the result is handed on; an allocation of size zero or into a full table skips the
// scan. Reset empties the table and sets the pool to its reset length; no clearing pass runs.
// A waiting result sits in the output register while the next item is processed; a second
// result then waits in the sequencer with the input stalled.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS,
    parameter int OFFSET_BITS = ffsa_pkg::DEF_OFFSET_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        op,
    input  logic [ffsa_pkg::LEN_W-1:0]  req_size,
    input  logic [ffsa_pkg::ADDR_W-1:0] req_address,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [ffsa_pkg::ADDR_W-1:0] block_address,
    output logic [ffsa_pkg::LEN_W-1:0]  bytes_free,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [ffsa_pkg::ADDR_W-1:0] cfg_data
);

    localparam logic [ffsa_pkg::LEN_W-1:0] LEN_RESET =
        ffsa_pkg::cap_pool_len(ffsa_pkg::POOL_SIZE_RESET, OFFSET_BITS);

    logic [ffsa_pkg::ADDR_W-1:0] pool_base_reg, pool_base_next;
    logic [ffsa_pkg::LEN_W-1:0]  pool_len_reg, pool_len_next;
    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  status_reg, status_next;
    logic [ffsa_pkg::ADDR_W-1:0] block_address_reg, block_address_next;
    logic [ffsa_pkg::LEN_W-1:0]  bytes_free_reg, bytes_free_next;

    logic                cfg_take;
    logic                out_free;
    ffsa_pkg::pool_cmd_t pool_cmd;
    ffsa_pkg::result_t   res;

    assign cfg_ready = 1'b1;
    assign cfg_take = cfg_valid && cfg_ready;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        pool_cmd.clear = cfg_take && (cfg_index == ffsa_pkg::REG_POOL_SIZE);
        pool_cmd.len = ffsa_pkg::cap_pool_len(cfg_data[ffsa_pkg::LEN_W-1:0], OFFSET_BITS);
        pool_base_next = pool_base_reg;
        pool_len_next = pool_len_reg;
        if (cfg_take && (cfg_index == ffsa_pkg::REG_POOL_BASE))
        begin
            pool_base_next = cfg_data;
        end
        if (pool_cmd.clear)
        begin
            pool_len_next = pool_cmd.len;
        end
    end

    ffsa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .req_size    (req_size),
        .req_address (req_address),
        .pool_base   (pool_base_reg),
        .pool_len    (pool_len_reg),
        .pool_cmd    (pool_cmd),
        .out_free    (out_free),
        .res         (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next = status_reg;
        block_address_next = block_address_reg;
        bytes_free_next = bytes_free_reg;
        if (res.valid)
        begin
            out_valid_next = 1'b1;
            status_next = res.status;
            block_address_next = res.addr;
            bytes_free_next = res.free;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
            pool_len_reg <= LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pool_base_reg <= pool_base_next;
            pool_len_reg <= pool_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        block_address_reg <= block_address_next;
        bytes_free_reg <= bytes_free_next;
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign block_address = block_address_reg;
    assign bytes_free = bytes_free_reg;

endmodule

// ===== verif/first_fit_segment_allocator_checker.sv =====
// Checker for the first-fit segment allocator: tracks the pool and compares every result.
module first_fit_segment_allocator_checker #(
    parameter int MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS,
    parameter int OFFSET_BITS = ffsa_pkg::DEF_OFFSET_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        op,
    input  logic [ffsa_pkg::LEN_W-1:0]  req_size,
    input  logic [ffsa_pkg::ADDR_W-1:0] req_address,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [1:0]                  status,
    input  logic [ffsa_pkg::ADDR_W-1:0] block_address,
    input  logic [ffsa_pkg::LEN_W-1:0]  bytes_free,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [ffsa_pkg::ADDR_W-1:0] cfg_data,
    output int                          mismatches,
    output int                          outstanding
);

    import ffsa_pkg::*;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  free;
    } alloc_reply_t;

    logic [ADDR_W-1:0]      pool_origin;
    logic [LEN_W-1:0]       pool_len;
    logic [OFFSET_BITS-1:0] seg_start [MAX_SEGMENTS];
    logic [LEN_W-1:0]       seg_len [MAX_SEGMENTS];
    int                     seg_used;
    logic [LEN_W-1:0]       free_bytes;
    alloc_reply_t           expected_replies [$];

    function automatic logic [LEN_W-1:0] clamp_pool_len(input logic [LEN_W-1:0] v);
        longint span;
        span = longint'(1) << OFFSET_BITS;
        if (longint'(v) > span)
        begin
            return LEN_W'(span);
        end
        return v;
    endfunction

    function automatic alloc_reply_t reply(input logic [1:0] st, input logic [ADDR_W-1:0] a);
        alloc_reply_t r;
        r.status = st;
        r.addr = a;
        r.free = free_bytes;
        return r;
    endfunction

    function automatic alloc_reply_t allocate_segment(input logic [LEN_W-1:0] n);
        longint prev_end;
        longint start;
        int pos;
        bit found;
        prev_end = 0;
        pos = seg_used;
        found = 1'b0;
        if (n == '0)
        begin
            return reply(STATUS_NOSPACE, '0);
        end
        if (seg_used >= MAX_SEGMENTS)
        begin
            return reply(STATUS_FULL, '0);
        end
        for (int i = 0; i < seg_used; i++)
        begin
            start = longint'(seg_start[i]);
            if (start >= prev_end && start - prev_end >= longint'(n))
            begin
                pos = i;
                found = 1'b1;
                break;
            end
            prev_end = start + longint'(seg_len[i]);
        end
        if (!found && longint'(pool_len) >= prev_end
            && longint'(pool_len) - prev_end >= longint'(n))
        begin
            pos = seg_used;
            found = 1'b1;
        end
        if (!found)
        begin
            return reply(STATUS_NOSPACE, '0);
        end
        for (int i = seg_used; i > pos; i--)
        begin
            seg_start[i] = seg_start[i-1];
            seg_len[i] = seg_len[i-1];
        end
        seg_start[pos] = OFFSET_BITS'(prev_end);
        seg_len[pos] = n;
        seg_used++;
        free_bytes = (free_bytes >= n) ? free_bytes - n : '0;
        return reply(STATUS_OK, pool_origin + ADDR_W'(prev_end));
    endfunction

    function automatic alloc_reply_t release_segment(input logic [ADDR_W-1:0] a);
        longint sum;
        for (int i = 0; i < seg_used; i++)
        begin
            if (pool_origin + ADDR_W'(seg_start[i]) == a)
            begin
                sum = longint'(free_bytes) + longint'(seg_len[i]);
                free_bytes = (sum > longint'(pool_len)) ? pool_len : LEN_W'(sum);
                for (int j = i; j + 1 < seg_used; j++)
                begin
                    seg_start[j] = seg_start[j+1];
                    seg_len[j] = seg_len[j+1];
                end
                seg_used--;
                return reply(STATUS_OK, '0);
            end
        end
        return reply(STATUS_NOTALLOC, '0);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_reply_t want;
        if (!rst_n)
        begin
            pool_origin = '0;
            pool_len = clamp_pool_len(POOL_SIZE_RESET);
            seg_used = 0;
            free_bytes = pool_len;
            expected_replies.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("Result with no item waiting: status %0d, address %h",
                           status, block_address);
                    mismatches++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatches++;
                    end
                    if (block_address !== want.addr)
                    begin
                        $error("block_address: expected %h, actual %h",
                               want.addr, block_address);
                        mismatches++;
                    end
                    if (bytes_free !== want.free)
                    begin
                        $error("bytes_free: expected %0d, actual %0d", want.free, bytes_free);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_POOL_BASE)
                begin
                    pool_origin = cfg_data;
                end
                else
                begin
                    pool_len = clamp_pool_len(cfg_data[LEN_W-1:0]);
                    seg_used = 0;
                    free_bytes = pool_len;
                end
            end
            if (in_valid && !in_stall)
            begin
                if (op == OP_ALLOC)
                begin
                    expected_replies.push_back(allocate_segment(req_size));
                end
                else
                begin
                    expected_replies.push_back(release_segment(req_address));
                end
            end
            outstanding = expected_replies.size();
        end
    end

endmodule

// ===== verif/first_fit_segment_allocator_test.sv =====
// Testbench top of the first-fit segment allocator: clock, reset, requests and verdict.
module first_fit_segment_allocator_test;

    import ffsa_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                op;
    logic [LEN_W-1:0]    req_size;
    logic [ADDR_W-1:0]   req_address;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          status;
    logic [ADDR_W-1:0]   block_address;
    logic [LEN_W-1:0]    bytes_free;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [ADDR_W-1:0]   cfg_data;

    int                  chk_mismatches;
    int                  chk_outstanding;

    logic                pending_ops [$];
    logic [ADDR_W-1:0]   held_addrs [$];
    logic [ADDR_W-1:0]   pool_origin;
    int                  pool_span;
    bit                  steady_mode = 1'b0;
    bit                  hold_request = 1'b0;
    int                  idle_cycles = 0;

    first_fit_segment_allocator i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .req_size(req_size),
        .req_address(req_address),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .block_address(block_address),
        .bytes_free(bytes_free),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    first_fit_segment_allocator_checker i_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .req_size(req_size),
        .req_address(req_address),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .block_address(block_address),
        .bytes_free(bytes_free),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(chk_mismatches),
        .outstanding(chk_outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic send_request(input logic o, input logic [LEN_W-1:0] n,
                                input logic [ADDR_W-1:0] a);
        @(negedge clk);
        while (!steady_mode && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        req_size <= n;
        req_address <= a;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_ops.push_back(o);
    endtask

    task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_POOL_SIZE)
        begin
            held_addrs.delete();
        end
    endtask

    task automatic wait_results;
        @(negedge clk);
        in_valid <= 1'b0;
        while (chk_outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic random_request;
        int pick;
        int k;
        logic [LEN_W-1:0] n;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(99);
        a = $urandom();
        if (pick < 45)
        begin
            k = $urandom_range(99);
            if (k < 4)
            begin
                n = '0;
            end
            else if (k < 9)
            begin
                n = LEN_W'($urandom_range(131071));
            end
            else if (k < 25)
            begin
                n = LEN_W'($urandom_range(pool_span, 1));
            end
            else
            begin
                n = LEN_W'($urandom_range(pool_span / 12 + 1, 1));
            end
            send_request(OP_ALLOC, n, a);
        end
        else if (pick < 85 && held_addrs.size() > 0)
        begin
            k = $urandom_range(held_addrs.size() - 1);
            a = held_addrs[k];
            held_addrs.delete(k);
            send_request(OP_FREE, LEN_W'($urandom()), a);
        end
        else
        begin
            if (pick < 93)
            begin
                a = pool_origin + ADDR_W'($urandom_range(pool_span));
            end
            send_request(OP_FREE, LEN_W'($urandom()), a);
        end
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size_data,
                             input int count, input bit steady, input bit hold);
        int v;
        wait_results();
        write_reg(REG_POOL_BASE, base);
        write_reg(REG_POOL_SIZE, size_data);
        v = int'(size_data[LEN_W-1:0]);
        pool_origin = base;
        pool_span = (v > (1 << DEF_OFFSET_BITS)) ? (1 << DEF_OFFSET_BITS) : v;
        steady_mode = steady;
        hold_request = hold;
        repeat (count)
        begin
            random_request();
        end
        steady_mode = 1'b0;
    endtask

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                out_stall <= !steady_mode && ($urandom_range(99) < 14);
            end
        end
    end

    always @(posedge clk)
    begin
        logic done_op;
        if (rst_n)
        begin
            if (out_valid && !out_stall && pending_ops.size() > 0)
            begin
                done_op = pending_ops.pop_front();
                if (done_op == OP_ALLOC && status == STATUS_OK)
                begin
                    held_addrs.push_back(block_address);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid <= 1'b0;
        op <= OP_ALLOC;
        req_size <= '0;
        req_address <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_POOL_BASE;
        cfg_data <= '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(OP_ALLOC, '0, '0);
        send_request(OP_ALLOC, 17'd65536, '1);
        send_request(OP_ALLOC, 17'd1, '0);
        send_request(OP_FREE, '0, 32'd0);
        send_request(OP_FREE, '0, 32'd0);
        send_request(OP_ALLOC, 17'h1FFFF, '0);
        send_request(OP_FREE, '1, 32'hFFFF_FFFF);
        repeat (DEF_MAX_SEGMENTS)
        begin
            send_request(OP_ALLOC, 17'd100, '0);
        end
        send_request(OP_ALLOC, 17'd1, '0);
        send_request(OP_FREE, '0, 32'd0);
        send_request(OP_ALLOC, 17'd50, '0);
        send_request(OP_FREE, '0, 32'd500);
        send_request(OP_ALLOC, 17'd100, '0);

        run_phase($urandom(), 32'd4096, 400, 1'b0, 1'b1);
        run_phase(32'hFFFF_F800, 32'hFFFE_0000 | 32'h0001_0000, 350, 1'b0, 1'b0);
        run_phase(32'h0000_0000, 32'h0000_0000, 40, 1'b0, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'd1, 60, 1'b0, 1'b0);
        run_phase($urandom(), 32'h0001_FFFF, 400, 1'b1, 1'b0);
        run_phase($urandom(), 32'd300, 300, 1'b0, 1'b0);
        run_phase($urandom(), $urandom_range(2000, 1), 400, 1'b0, 1'b0);

        @(negedge clk);
        in_valid <= 1'b0;
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (chk_mismatches == 0 && chk_outstanding == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ffsa_pkg.sv
design/ffsa_table.sv
design/ffsa_unit.sv
design/ffsa_ctrl.sv
design/first_fit_segment_allocator.sv
verif/first_fit_segment_allocator_checker.sv
verif/first_fit_segment_allocator_test.sv
